/* hw/rtl/snmppa_pkg.sv */
// Shared types and constants for the SNMP request packet assembler.
// Holds sequencer states, write-sequence kinds, status codes and fixed BER bytes.
// No dependencies.
package snmppa_pkg;

   // Item modes
   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_COMM  = 3'd1;
   localparam logic [2:0] MODE_ARC   = 3'd2;
   localparam logic [2:0] MODE_COMMIT = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   // Configuration register indexes
   localparam logic CSR_COMMAND_TYPE = 1'b0;
   localparam logic CSR_REQUEST_ID   = 1'b1;

   // Width of one combined subidentifier (40*a+b with 31-bit arcs)
   localparam int VW = 38;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_COMM_LONG  = 3'd1,
      STAT_OID_SHORT  = 3'd2,
      STAT_LEN_OVER   = 3'd3,
      STAT_STORE_FULL = 3'd4,
      STAT_BAD_READ   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SUBCHK,
      ST_CLOSECHK,
      ST_WRITE,
      ST_READ,
      ST_RDATA,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      SEQ_HEAD,
      SEQ_COMM,
      SEQ_PDU,
      SEQ_VBOPEN,
      SEQ_SUBID,
      SEQ_CLOSE,
      SEQ_COMMIT
   } seq_type;

   typedef logic [7:0] byte_type;

   // Message header, version and community tag
   localparam byte_type HEAD_BYTES [9] = '{
      8'h30, 8'h82, 8'h00, 8'h00, 8'h02, 8'h01, 8'h01, 8'h04, 8'h00};

   // PDU header template; tag and request id bytes are patched in
   localparam byte_type PDU_BYTES [20] = '{
      8'h00, 8'h82, 8'h00, 8'h00, 8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h02, 8'h01, 8'h00, 8'h02, 8'h01, 8'h00, 8'h30, 8'h82, 8'h00, 8'h00};

   // Varbind sequence and OID tag with empty lengths
   localparam byte_type VB_BYTES [4] = '{8'h30, 8'h00, 8'h06, 8'h00};

   localparam byte_type TAG_NULL = 8'h05;

endpackage

/* hw/rtl/snmp_request_packet_assembler_unit.sv */
// SNMPv2c request packet assembler: BER encoder writing one byte per cycle
// into a packet store. Depends on snmppa_pkg and snmppa_ram.
//
// Usage:
// - The req_ channel carries one item: start, community byte, OID arc,
//   commit or read. Each accepted item gives exactly one rsp_ transfer with
//   status, read byte and current packet length.
// - The csr_ port writes command_type (index 0) and request_id (index 1);
//   write only while the block is idle.
// - One item is in work at a time; req_stall stays high until it is done.
//   A single byte-write sequencer does all work, one store byte per cycle:
//   start writes the header; a community byte is appended; the first arc of
//   an OID opens a varbind; each other arc writes its encoded bytes (1 to 6),
//   and the last arc adds the closing NULL; commit patches the header
//   fields. The first arc or commit after the community adds the PDU header.
// - A result sits in an output register; while rsp_stall is high it holds
//   and no new item is taken.
// - Reset writes the 9 header bytes into the store (no item is accepted
//   meanwhile), restores command_type 0xA0 and request_id 0, and
//   acts as a start without producing a result.
module snmp_request_packet_assembler_unit
   import snmppa_pkg::*;
#(
   parameter int STORE_BYTES   = 1024,
   parameter int MAX_COMMUNITY = 127
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_data_byte,
   input  logic [30:0] req_arc_value,
   input  logic        req_last_arc,
   input  logic [9:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_read_byte,
   output logic [10:0] rsp_packet_length,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam int PW = $clog2(STORE_BYTES + 1);
   localparam int XW = PW + 16;

   // Registers
   state_type   state_ff, state_in;
   seq_type     seq_ff, seq_in;
   logic [4:0]  step_ff, step_in;
   logic [2:0]  n_ff, n_in;
   logic [VW-1:0] v_ff, v_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [7:0]  cl_ff, cl_in;
   logic [PW-1:0] vs_ff, vs_in;
   logic [PW-1:0] os_ff, os_in;
   logic [7:0]  ac_ff, ac_in;
   logic [30:0] first_ff, first_in;
   status_type  err_ff, err_in;
   logic        inb_ff, inb_in;
   logic        silent_ff, silent_in;
   logic [7:0]  cmd_ff;
   logic [31:0] rid_ff;
   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  data_ff, data_in;
   logic [30:0] arc_ff, arc_in;
   logic        last_ff, last_in;
   logic [9:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [10:0] rsp_len_ff, rsp_len_in;

   // Store port signals
   logic          ram_we;
   logic [XW-1:0] gen_addr;
   logic [7:0]    gen_data;
   logic          gen_last;
   logic [7:0]    ram_rdata;

   // Extended views for arithmetic
   logic [XW-1:0] wp_x, vs_x, os_x, c_x, idx_x, len_all, len_pdu, len_vbl, len_oid, len_vb;
   logic [XW-1:0] n_x, sub_n_x;
   logic [2:0]    sub_n;
   logic          accept;
   logic          read_ok;

   assign wp_x    = XW'(wp_ff);
   assign vs_x    = XW'(vs_ff);
   assign os_x    = XW'(os_ff);
   assign c_x     = XW'(cl_ff) + XW'(9);
   assign idx_x   = XW'(idx_ff);
   assign n_x     = XW'(n_ff);
   assign len_all = wp_x - XW'(4);
   assign len_pdu = wp_x - c_x - XW'(4);
   assign len_vbl = wp_x - c_x - XW'(20);
   assign len_oid = wp_x - os_x - XW'(2);
   assign len_vb  = wp_x - vs_x;
   assign read_ok = (idx_x < wp_x) && (idx_x < XW'(STORE_BYTES));

   // Count base-128 digits of the pending subidentifier
   always_comb begin
      sub_n = 3'd1;
      for (int k = 1; k < 6; k++) begin
         if (v_ff >= (VW'(1) << (7 * k))) begin
            sub_n = sub_n + 3'd1;
         end
      end
   end
   assign sub_n_x = XW'(sub_n);

   assign accept    = req_valid && !req_stall;
   assign req_stall = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));

   // Address and data of the current byte of the running write sequence
   always_comb begin
      gen_addr = XW'(step_ff);
      gen_data = 8'h00;
      gen_last = 1'b0;
      case (seq_ff)
         SEQ_HEAD: begin
            gen_data = HEAD_BYTES[step_ff[3:0]];
            gen_last = (step_ff == 5'd8);
         end
         SEQ_COMM: begin
            gen_addr = (step_ff == 5'd0) ? wp_x : XW'(8);
            gen_data = (step_ff == 5'd0) ? data_ff : cl_ff + 8'd1;
            gen_last = (step_ff == 5'd1);
         end
         SEQ_PDU: begin
            gen_addr = wp_x + XW'(step_ff);
            case (step_ff)
               5'd0:    gen_data = cmd_ff;
               5'd6:    gen_data = rid_ff[31:24];
               5'd7:    gen_data = rid_ff[23:16];
               5'd8:    gen_data = rid_ff[15:8];
               5'd9:    gen_data = rid_ff[7:0];
               5'd20: begin
                  gen_addr = XW'(8);
                  gen_data = cl_ff;
               end
               default: gen_data = PDU_BYTES[step_ff];
            endcase
            gen_last = (step_ff == 5'd20);
         end
         SEQ_VBOPEN: begin
            gen_addr = wp_x + XW'(step_ff);
            gen_data = VB_BYTES[step_ff[1:0]];
            gen_last = (step_ff == 5'd3);
         end
         SEQ_SUBID: begin
            // Low digit first, at the highest address
            gen_addr = wp_x + n_x - XW'(1) - XW'(step_ff);
            gen_data = {(step_ff != 5'd0), v_ff[6:0]};
            gen_last = (step_ff == 5'(n_ff - 3'd1));
         end
         SEQ_CLOSE: begin
            case (step_ff[1:0])
               2'd0: begin
                  gen_addr = os_x + XW'(1);
                  gen_data = len_oid[7:0];
               end
               2'd1: begin
                  gen_addr = wp_x;
                  gen_data = TAG_NULL;
               end
               2'd2: begin
                  gen_addr = wp_x + XW'(1);
                  gen_data = 8'h00;
               end
               default: begin
                  gen_addr = vs_x + XW'(1);
                  gen_data = len_vb[7:0];
               end
            endcase
            gen_last = (step_ff == 5'd3);
         end
         SEQ_COMMIT: begin
            case (step_ff)
               5'd0: begin gen_addr = c_x;            gen_data = cmd_ff;         end
               5'd1: begin gen_addr = c_x + XW'(6);   gen_data = rid_ff[31:24];  end
               5'd2: begin gen_addr = c_x + XW'(7);   gen_data = rid_ff[23:16];  end
               5'd3: begin gen_addr = c_x + XW'(8);   gen_data = rid_ff[15:8];   end
               5'd4: begin gen_addr = c_x + XW'(9);   gen_data = rid_ff[7:0];    end
               5'd5: begin gen_addr = XW'(8);         gen_data = cl_ff;          end
               5'd6: begin gen_addr = XW'(2);         gen_data = len_all[15:8];  end
               5'd7: begin gen_addr = XW'(3);         gen_data = len_all[7:0];   end
               5'd8: begin gen_addr = c_x + XW'(2);   gen_data = len_pdu[15:8];  end
               5'd9: begin gen_addr = c_x + XW'(3);   gen_data = len_pdu[7:0];   end
               5'd10: begin gen_addr = c_x + XW'(18); gen_data = len_vbl[15:8];  end
               default: begin gen_addr = c_x + XW'(19); gen_data = len_vbl[7:0]; end
            endcase
            gen_last = (step_ff == 5'd11);
         end
         default: begin
            gen_last = 1'b1;
         end
      endcase
   end

   // Sequencer: next state and register updates
   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      step_in       = step_ff;
      n_in          = n_ff;
      v_in          = v_ff;
      wp_in         = wp_ff;
      cl_in         = cl_ff;
      vs_in         = vs_ff;
      os_in         = os_ff;
      ac_in         = ac_ff;
      first_in      = first_ff;
      err_in        = err_ff;
      inb_in        = inb_ff;
      silent_in     = silent_ff;
      mode_in       = mode_ff;
      data_in       = data_ff;
      arc_in        = arc_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_len_in    = rsp_len_ff;
      ram_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               data_in = req_data_byte;
               arc_in  = req_arc_value;
               last_in = req_last_arc;
               idx_in  = req_read_index;
               if (req_mode == MODE_START) begin
                  cl_in     = 8'd0;
                  vs_in     = '0;
                  os_in     = '0;
                  ac_in     = 8'd0;
                  first_in  = '0;
                  err_in    = STAT_OK;
                  inb_in    = 1'b0;
                  silent_in = 1'b0;
                  seq_in    = SEQ_HEAD;
                  step_in   = 5'd0;
                  state_in  = ST_WRITE;
               end else if (req_mode == MODE_READ) begin
                  state_in = ST_READ;
               end else if ((req_mode == MODE_COMM || req_mode == MODE_ARC ||
                             req_mode == MODE_COMMIT) && err_ff == STAT_OK) begin
                  state_in = ST_EVAL;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_EVAL: begin
            step_in  = 5'd0;
            state_in = ST_RESP;
            if (mode_ff == MODE_COMM) begin
               if (inb_ff) begin
                  state_in = ST_RESP;
               end else if (cl_ff >= 8'(MAX_COMMUNITY)) begin
                  err_in = STAT_COMM_LONG;
               end else if (wp_x >= XW'(STORE_BYTES)) begin
                  err_in = STAT_STORE_FULL;
               end else begin
                  seq_in   = SEQ_COMM;
                  state_in = ST_WRITE;
               end
            end else if (!inb_ff) begin
               // Close the community and lay down the PDU header first
               if (wp_x + XW'(20) > XW'(STORE_BYTES)) begin
                  err_in = STAT_STORE_FULL;
               end else begin
                  seq_in   = SEQ_PDU;
                  state_in = ST_WRITE;
               end
            end else if (mode_ff == MODE_ARC) begin
               if (ac_ff == 8'd0) begin
                  if (last_ff) begin
                     err_in = STAT_OID_SHORT;
                  end else if (wp_x + XW'(4) > XW'(STORE_BYTES)) begin
                     err_in = STAT_STORE_FULL;
                  end else begin
                     vs_in    = wp_ff;
                     os_in    = PW'(wp_x + XW'(2));
                     first_in = arc_ff;
                     ac_in    = 8'd1;
                     seq_in   = SEQ_VBOPEN;
                     state_in = ST_WRITE;
                  end
               end else begin
                  if (ac_ff == 8'd1) begin
                     v_in = (VW'(first_ff) << 5) + (VW'(first_ff) << 3) + VW'(arc_ff);
                  end else begin
                     v_in = VW'(arc_ff);
                  end
                  state_in = ST_SUBCHK;
               end
            end else begin
               if (ac_ff != 8'd0) begin
                  err_in = STAT_OID_SHORT;
               end else begin
                  seq_in   = SEQ_COMMIT;
                  state_in = ST_WRITE;
               end
            end
         end

         ST_SUBCHK: begin
            step_in = 5'd0;
            if (wp_x + sub_n_x > XW'(STORE_BYTES)) begin
               err_in   = STAT_STORE_FULL;
               state_in = ST_RESP;
            end else if (wp_x + sub_n_x > os_x + XW'(129)) begin
               err_in   = STAT_LEN_OVER;
               state_in = ST_RESP;
            end else begin
               n_in     = sub_n;
               seq_in   = SEQ_SUBID;
               state_in = ST_WRITE;
            end
         end

         ST_CLOSECHK: begin
            step_in  = 5'd0;
            state_in = ST_RESP;
            if (wp_x + XW'(2) > XW'(STORE_BYTES)) begin
               err_in = STAT_STORE_FULL;
            end else if (len_vb > XW'(127)) begin
               err_in = STAT_LEN_OVER;
            end else begin
               seq_in   = SEQ_CLOSE;
               state_in = ST_WRITE;
            end
         end

         ST_WRITE: begin
            ram_we  = 1'b1;
            step_in = step_ff + 5'd1;
            if (seq_ff == SEQ_SUBID) begin
               v_in = v_ff >> 7;
            end
            if (gen_last) begin
               step_in  = 5'd0;
               state_in = ST_RESP;
               case (seq_ff)
                  SEQ_HEAD: begin
                     wp_in = PW'(9);
                     if (silent_ff) begin
                        silent_in = 1'b0;
                        state_in  = ST_IDLE;
                     end
                  end
                  SEQ_COMM: begin
                     wp_in = wp_ff + PW'(1);
                     cl_in = cl_ff + 8'd1;
                  end
                  SEQ_PDU: begin
                     wp_in    = PW'(wp_x + XW'(20));
                     inb_in   = 1'b1;
                     state_in = ST_EVAL;
                  end
                  SEQ_VBOPEN: begin
                     wp_in = PW'(wp_x + XW'(4));
                  end
                  SEQ_SUBID: begin
                     wp_in = PW'(wp_x + n_x);
                     if (ac_ff == 8'd1) begin
                        ac_in = 8'd2;
                     end else if (ac_ff != 8'hFF) begin
                        ac_in = ac_ff + 8'd1;
                     end
                     if (last_ff) begin
                        state_in = ST_CLOSECHK;
                     end
                  end
                  SEQ_CLOSE: begin
                     wp_in = PW'(wp_x + XW'(2));
                     ac_in = 8'd0;
                  end
                  default: begin
                     wp_in = wp_ff;
                  end
               endcase
            end
         end

         ST_READ: begin
            state_in = ST_RDATA;
         end

         ST_RDATA: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = read_ok ? err_ff : STAT_BAD_READ;
            rsp_byte_in   = read_ok ? ram_rdata : 8'h00;
            rsp_len_in    = wp_x[10:0];
            state_in      = ST_IDLE;
         end

         ST_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = err_in;
            rsp_byte_in   = 8'h00;
            rsp_len_in    = wp_x[10:0];
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WRITE;
         seq_ff       <= SEQ_HEAD;
         step_ff      <= 5'd0;
         wp_ff        <= '0;
         cl_ff        <= 8'd0;
         vs_ff        <= '0;
         os_ff        <= '0;
         ac_ff        <= 8'd0;
         first_ff     <= '0;
         err_ff       <= STAT_OK;
         inb_ff       <= 1'b0;
         silent_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         step_ff      <= step_in;
         wp_ff        <= wp_in;
         cl_ff        <= cl_in;
         vs_ff        <= vs_in;
         os_ff        <= os_in;
         ac_ff        <= ac_in;
         first_ff     <= first_in;
         err_ff       <= err_in;
         inb_ff       <= inb_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= 8'hA0;
         rid_ff <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COMMAND_TYPE: cmd_ff <= csr_wdata[7:0];
            CSR_REQUEST_ID:   rid_ff <= csr_wdata;
            default:          cmd_ff <= cmd_ff;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      v_ff          <= v_in;
      mode_ff       <= mode_in;
      data_ff       <= data_in;
      arc_ff        <= arc_in;
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // Packet store
   snmppa_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (gen_addr[AW-1:0]),
      .wr_data (gen_data),
      .rd_addr (idx_x[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_byte     = rsp_byte_ff;
   assign rsp_packet_length = rsp_len_ff;

endmodule

/* hw/rtl/snmppa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module snmppa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
